// ----- src/assert_macros.svh -----
// assertion macros used by the tracker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge once reset is released
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ANY(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/ioct_pkg.sv -----
// shared types and constants of the in-order completion tracker
`default_nettype none

package ioct_pkg;

	localparam int IDX_W  = 10;  // task index width
	localparam int CNT_W  = 11;  // list size, head and count width
	localparam int WORD_W = 32;  // ready bits per memory row
	localparam int OFF_W  = 5;   // bit offset inside a row

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MARK,
		ST_READ,
		ST_EVAL
	} state_t;

endpackage

`default_nettype wire

// ----- src/ioct_if.sv -----
// request and result channel interfaces of the in-order completion tracker
`default_nettype none

interface ioct_done_if;
	logic                       valid;
	logic                       ready;
	logic [ioct_pkg::IDX_W-1:0] done_index;

	modport source (output valid, output done_index, input ready);
	modport sink (input valid, input done_index, output ready);
endinterface

interface ioct_retire_if;
	logic                       valid;
	logic                       ready;
	logic                       accepted;
	logic [ioct_pkg::CNT_W-1:0] first_released;
	logic [ioct_pkg::CNT_W-1:0] released_count;

	modport source (output valid, output accepted, output first_released,
		output released_count, input ready);
	modport sink (input valid, input accepted, input first_released,
		input released_count, output ready);
endinterface

`default_nettype wire

// ----- src/in_order_completion_tracker.sv -----
// in-order completion tracker: marks finished tasks and retires them in order
//
// - done channel: one request per finished task, carrying done_index. an
//   index below the effective list size (size register clamped to DEPTH)
//   sets its ready bit; any other index is rejected and marks nothing
// - retire channel: one result per request, with accepted, first_released
//   (head before the request) and released_count (run of ready entries
//   retired from the head, possibly zero)
// - cfg_we / cfg_wdata write the list size; write it only while the block is idle
// - flow: a request is taken in idle while its memory row is read, the marked
//   bit is written back, then the head's row is read and scanned, the read and
//   scan repeating each time the run reaches a row end and the list goes on;
//   the result is then stored and the block returns to idle, so a new request
//   is taken only after the last one is through
// - the result sits in an output register, so a new request is taken while
//   the last result waits; a stalled receiver holds the block only when the
//   next result is ready to be stored
// - reset: head goes to zero, the list size to 1024, and a clearing pass
//   writes zero to all ceil(DEPTH/32) memory rows while done.ready stays low
`default_nettype none
`include "assert_macros.svh"

module in_order_completion_tracker #(
	parameter int DEPTH = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [ioct_pkg::CNT_W-1:0] cfg_wdata,
	ioct_done_if.sink                       done,
	ioct_retire_if.source                   retire
);

	localparam int ROWS   = (DEPTH + ioct_pkg::WORD_W - 1) / ioct_pkg::WORD_W;
	localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CNT_W  = ioct_pkg::CNT_W;
	localparam int OFF_W  = ioct_pkg::OFF_W;
	localparam int WORD_W = ioct_pkg::WORD_W;
	// largest list size the 11-bit register can reach within the store
	localparam logic [CNT_W-1:0] SIZE_CAP =
		(DEPTH > 2047) ? {CNT_W{1'b1}} : CNT_W'(DEPTH);
	localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

	// ready bit memory, one row of 32 task indices per entry
	logic [WORD_W-1:0] mem [ROWS];
	logic [WORD_W-1:0] rdata_q;

	ioct_pkg::state_t state_q, state_d;

	logic [ROW_AW-1:0] clr_q;
	logic [CNT_W-1:0]  size_limit_q;
	logic [CNT_W-1:0]  head_q;
	logic [CNT_W-1:0]  cur_q;
	logic [OFF_W-1:0]  bit_q;
	logic              acc_q;

	logic              out_valid_q;
	logic              out_acc_q;
	logic [CNT_W-1:0]  out_first_q;
	logic [CNT_W-1:0]  out_count_q;

	// memory port controls
	logic              re;
	logic [ROW_AW-1:0] raddr;
	logic              we;
	logic [ROW_AW-1:0] waddr;
	logic [WORD_W-1:0] wdata;

	logic              take;
	logic              load;
	logic [CNT_W-1:0]  size_eff;
	logic              idx_ok;

	// scan of the current row
	logic [OFF_W-1:0]  off;
	logic [WORD_W-1:0] shifted;
	logic [OFF_W:0]    ones;
	logic [OFF_W:0]    room;
	logic [CNT_W-1:0]  avail;
	logic [CNT_W-1:0]  run;
	logic [CNT_W-1:0]  next_cur;
	logic              more;

	// length of the run of ones starting at bit zero
	function automatic logic [OFF_W:0] lead_run(input logic [WORD_W-1:0] w);
		logic [OFF_W:0] n;
		n = (OFF_W + 1)'(WORD_W);
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!w[i]) begin
				n = (OFF_W + 1)'(i);
			end
		end
		return n;
	endfunction

	assign size_eff = (size_limit_q > SIZE_CAP) ? SIZE_CAP : size_limit_q;
	assign idx_ok   = {1'b0, done.done_index} < size_eff;
	assign take     = done.valid && done.ready;

	assign off      = cur_q[OFF_W-1:0];
	assign shifted  = rdata_q >> off;
	assign ones     = lead_run(shifted);
	assign room     = (OFF_W + 1)'(WORD_W) - {1'b0, off};
	assign avail    = (cur_q < size_eff) ? (size_eff - cur_q) : '0;
	assign run      = (CNT_W'(ones) < avail) ? CNT_W'(ones) : avail;
	assign next_cur = cur_q + run;
	// the run ran off the end of the row and the list goes on
	assign more     = (ones == room) && (next_cur < size_eff);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ioct_pkg::ST_CLEAR: begin
				if (clr_q == LAST_ROW) begin
					state_d = ioct_pkg::ST_IDLE;
				end
			end
			ioct_pkg::ST_IDLE: begin
				if (take) begin
					state_d = ioct_pkg::ST_MARK;
				end
			end
			ioct_pkg::ST_MARK: begin
				state_d = ioct_pkg::ST_READ;
			end
			ioct_pkg::ST_READ: begin
				state_d = ioct_pkg::ST_EVAL;
			end
			ioct_pkg::ST_EVAL: begin
				if (more) begin
					state_d = ioct_pkg::ST_READ;
				end else if (!out_valid_q || retire.ready) begin
					state_d = ioct_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ioct_pkg::ST_CLEAR;
			end
		endcase
	end

	// state outputs
	always_comb begin
		re         = 1'b0;
		raddr      = ROW_AW'(cur_q[CNT_W-1:OFF_W]);
		we         = 1'b0;
		waddr      = ROW_AW'(cur_q[CNT_W-1:OFF_W]);
		wdata      = rdata_q;
		load       = 1'b0;
		done.ready = 1'b0;
		unique case (state_q)
			ioct_pkg::ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			ioct_pkg::ST_IDLE: begin
				done.ready = 1'b1;
				re         = take;
				raddr      = ROW_AW'(done.done_index[ioct_pkg::IDX_W-1:OFF_W]);
			end
			ioct_pkg::ST_MARK: begin
				// cur_q still holds the marked index here
				we    = acc_q;
				wdata = rdata_q | (WORD_W'(1) << bit_q);
			end
			ioct_pkg::ST_READ: begin
				re = 1'b1;
			end
			ioct_pkg::ST_EVAL: begin
				load = !more && (!out_valid_q || retire.ready);
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	// memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ioct_pkg::ST_CLEAR;
			clr_q        <= '0;
			size_limit_q <= CNT_W'(1024);
			head_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ioct_pkg::ST_CLEAR) begin
				clr_q <= clr_q + ROW_AW'(1);
			end
			if (cfg_we) begin
				size_limit_q <= cfg_wdata;
			end
			if (load) begin
				head_q      <= next_cur;
				out_valid_q <= 1'b1;
			end else if (retire.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and scan payload
	always_ff @(posedge clk) begin
		if (take) begin
			acc_q <= idx_ok;
			bit_q <= done.done_index[OFF_W-1:0];
			cur_q <= {1'b0, done.done_index};
		end else if (state_q == ioct_pkg::ST_MARK) begin
			cur_q <= head_q;
		end else if (state_q == ioct_pkg::ST_EVAL && more) begin
			cur_q <= next_cur;
		end
		if (load) begin
			out_acc_q   <= acc_q;
			out_first_q <= head_q;
			out_count_q <= next_cur - head_q;
		end
	end

	assign retire.valid          = out_valid_q;
	assign retire.accepted       = out_acc_q;
	assign retire.first_released = out_first_q;
	assign retire.released_count = out_count_q;

	`ASSERT_CLK(a_head_matches_result, load |=> (head_q == out_first_q + out_count_q), "head does not follow the reported run")
	`ASSERT_CLK(a_head_monotonic, 1'b1 |=> (head_q >= $past(head_q)), "head moved backward")
	`ASSERT_CLK(a_write_states, we |-> (state_q == ioct_pkg::ST_MARK || state_q == ioct_pkg::ST_CLEAR), "memory written outside mark or clear")
	`ASSERT_ANY(a_reset_clears, !arst_n |-> (state_q == ioct_pkg::ST_CLEAR && !out_valid_q), "reset does not restart the clearing pass")

endmodule

`default_nettype wire

// ----- tb/ioct_retire_checker.sv -----
// scoreboard of the in-order completion tracker: predicts every retire result and checks it
`timescale 1ns / 100ps

module ioct_retire_checker #(
	parameter int TASK_DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ioct_pkg::CNT_W-1:0] cfg_wdata,
	input  logic                       end_of_run,
	ioct_done_if                       done,
	ioct_retire_if                     retire,
	output int                         mismatch_count
);

	localparam int CNT_W = ioct_pkg::CNT_W;
	localparam int IDX_W = ioct_pkg::IDX_W;

	typedef struct packed {
		logic             accepted;
		logic [CNT_W-1:0] first_released;
		logic [CNT_W-1:0] released_count;
	} retire_t;

	bit               task_ready [TASK_DEPTH];
	logic [CNT_W-1:0] size_limit_q;
	logic [CNT_W-1:0] head_q;
	retire_t          retire_expected_q [$];

	int unsigned n_requests, n_rejected, n_retired, longest_run, n_results;
	bit          summary_done;

	initial mismatch_count = 0;

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	task automatic check_field(input string field, input logic [CNT_W-1:0] got,
		input logic [CNT_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got %0d want %0d",
				n_results, field, got, want));
	endtask

	// mark the finished task, then retire the ready run from the head
	function automatic retire_t predict_retire(input logic [IDX_W-1:0] idx);
		retire_t     r;
		int unsigned limit;
		int unsigned pos;
		limit = (size_limit_q > TASK_DEPTH) ? TASK_DEPTH : size_limit_q;
		r.accepted = (idx < limit);
		if (r.accepted)
			task_ready[idx] = 1'b1;
		r.first_released = head_q;
		pos = head_q;
		while (pos < limit && task_ready[pos])
			pos++;
		r.released_count = CNT_W'(pos - head_q);
		head_q = CNT_W'(pos);
		n_requests++;
		if (!r.accepted)
			n_rejected++;
		n_retired += r.released_count;
		if (r.released_count > longest_run)
			longest_run = r.released_count;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		retire_t want;
		if (!arst_n) begin
			foreach (task_ready[i])
				task_ready[i] = 1'b0;
			size_limit_q = 11'd1024;
			head_q       = '0;
			retire_expected_q.delete();
		end else begin
			if (cfg_we)
				size_limit_q = cfg_wdata;
			if (done.valid && done.ready)
				retire_expected_q.insert(retire_expected_q.size(),
					predict_retire(done.done_index));
			if (retire.valid && retire.ready) begin
				if (retire_expected_q.size() == 0) begin
					report_mismatch("retire result with no request outstanding");
				end else begin
					want = retire_expected_q.pop_front();
					check_field("accepted", CNT_W'(retire.accepted), CNT_W'(want.accepted));
					check_field("first_released", retire.first_released, want.first_released);
					check_field("released_count", retire.released_count, want.released_count);
				end
				n_results++;
			end
			if (end_of_run && !summary_done) begin
				summary_done = 1'b1;
				if (retire_expected_q.size() != 0)
					report_mismatch($sformatf("%0d retire results never arrived",
						retire_expected_q.size()));
				$display("covered %0d requests (%0d rejected), %0d tasks retired in order",
					n_requests, n_rejected, n_retired);
				$display("longest retired run %0d, head finished at %0d", longest_run, head_q);
			end
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// testbench top of the in-order completion tracker: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_top;

	localparam int CNT_W        = ioct_pkg::CNT_W;
	localparam int IDX_W        = ioct_pkg::IDX_W;
	localparam int TASK_DEPTH   = 1024;
	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 11;
	localparam int RANDOM_REQS  = 750;
	// worst retire latency grows with the number of rows a run spans
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_AFTER   = 600;
	localparam int HOLD_CYCLES  = 400;
	localparam int TIMEOUT_NS   = 5_000_000;
	localparam int NOISE_PCT    = 15;
	localparam int SIZE_MAX     = (1 << CNT_W) - 1;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;
	logic             end_of_run;
	int               mismatch_count;

	// idle odds in percent, changed between phases
	int unsigned tx_idle_pct = 30;
	int unsigned rx_idle_pct = 75;

	int unsigned requests_sent;
	int unsigned results_seen;
	// every index below this one has been sent as a finished task
	int unsigned fresh_base;
	int unsigned random_sent;

	ioct_done_if   done_if();
	ioct_retire_if retire_if();

	in_order_completion_tracker #(
		.DEPTH(TASK_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.done     (done_if),
		.retire   (retire_if)
	);

	ioct_retire_checker #(
		.TASK_DEPTH(TASK_DEPTH)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.end_of_run    (end_of_run),
		.done          (done_if),
		.retire        (retire_if),
		.mismatch_count(mismatch_count)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// results taken by the receiver, used to know when the block is idle
	always @(posedge clk) begin
		if (arst_n && retire_if.valid && retire_if.ready)
			results_seen <= results_seen + 1;
	end

	// receiver: random stalls, plus one long hold-off so the block fills and stalls requests
	initial begin : receiver
		bit held;
		retire_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				retire_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			retire_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// hard stop in case a handshake never completes
	initial begin
		#(TIMEOUT_NS);
		$display("Some tests failed");
		$finish;
	end

	// offer one request, with random idle cycles in front; entered and left at a falling edge
	task automatic send_request(input int unsigned idx);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			done_if.valid <= 1'b0;
			@(negedge clk);
		end
		done_if.valid      <= 1'b1;
		done_if.done_index <= IDX_W'(idx);
		do @(posedge clk); while (!done_if.ready);
		requests_sent++;
		@(negedge clk);
	endtask

	// drop valid and wait until every request has its result back
	task automatic wait_idle();
		done_if.valid <= 1'b0;
		while (results_seen != requests_sent)
			@(negedge clk);
	endtask

	// the list size is only written with nothing in flight
	task automatic write_size_limit(input int unsigned value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value[CNT_W-1:0];
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// a request outside the well-formed order: random, repeated or beyond the list
	task automatic send_noise(input int unsigned size);
		int unsigned idx;
		case ($urandom_range(0, 2))
			0: idx = $urandom_range(0, TASK_DEPTH - 1);
			1: idx = (fresh_base > 0) ? $urandom_range(0, fresh_base - 1) : 0;
			default: idx = (size < TASK_DEPTH) ? $urandom_range(size, TASK_DEPTH - 1) :
				$urandom_range(0, TASK_DEPTH - 1);
		endcase
		send_request(idx);
		random_sent++;
	endtask

	// one round: pick a list size, then finish every new task in it in some order
	task automatic run_round();
		int unsigned batch [$];
		int unsigned new_size;
		int unsigned span;
		int unsigned order;
		int unsigned pick;
		int unsigned tmp;
		int unsigned n;
		if (fresh_base >= TASK_DEPTH) begin
			// everything retired already: only repeats and rejects are left
			write_size_limit($urandom_range(TASK_DEPTH, SIZE_MAX));
			repeat ($urandom_range(4, 10))
				send_noise(TASK_DEPTH);
		end else if (fresh_base > 0 && $urandom_range(0, 7) == 0) begin
			// list shrunk to the head or below: nothing may retire
			new_size = $urandom_range(0, fresh_base);
			write_size_limit(new_size);
			repeat ($urandom_range(2, 5))
				send_noise(new_size);
		end else begin
			// mostly short lists, now and then a long one so a run spans several rows
			span = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 24);
			new_size = fresh_base + span;
			if (new_size >= TASK_DEPTH) begin
				new_size = TASK_DEPTH;
				write_size_limit($urandom_range(0, 1) ? TASK_DEPTH :
					$urandom_range(TASK_DEPTH + 1, SIZE_MAX));
			end else begin
				write_size_limit(new_size);
			end
			for (int unsigned j = fresh_base; j < new_size; j++)
				batch.insert(batch.size(), j);
			n = batch.size();
			// shuffled, head last (one long run) or in order (runs of one)
			order = $urandom_range(0, 4);
			if (order < 3) begin
				for (int unsigned j = n - 1; j > 0; j--) begin
					pick        = $urandom_range(0, j);
					tmp         = batch[j];
					batch[j]    = batch[pick];
					batch[pick] = tmp;
				end
			end
			for (int unsigned k = 0; k < n; k++) begin
				if ($urandom_range(0, 99) < NOISE_PCT)
					send_noise(new_size);
				send_request((order == 3) ? batch[n - 1 - k] : batch[k]);
				random_sent++;
			end
			fresh_base = new_size;
		end
	endtask

	initial begin
		done_if.valid      = 1'b0;
		done_if.done_index = '0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		end_of_run         = 1'b0;
		arst_n             = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset list size, out of order marks, run of two from the head
		send_request(1);
		send_request(6);
		send_request(0);
		// empty list: every index rejected, head above the list
		write_size_limit(0);
		send_request(0);
		send_request(TASK_DEPTH - 1);
		// oversized list acts as the full depth
		write_size_limit(SIZE_MAX);
		send_request(TASK_DEPTH - 1);
		send_request(5);
		send_request(3);
		send_request(2);
		// list end stops the run even though later entries are ready
		write_size_limit(5);
		send_request(4);
		send_request(5);
		send_request(7);
		// list grown again: a rejected request still retires the marks made earlier
		write_size_limit(8);
		send_request(1000);
		send_request(7);
		fresh_base = 8;

		// random: three idling phases, the last with no idling at all
		while (random_sent < RANDOM_REQS) begin
			if (random_sent >= 2 * RANDOM_REQS / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else if (random_sent >= RANDOM_REQS / 3) begin
				tx_idle_pct = 75;
				rx_idle_pct = 30;
			end
			run_round();
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		end_of_run <= 1'b1;
		repeat (2) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- in_order_completion_tracker.f -----
+incdir+src
src/ioct_pkg.sv
src/ioct_if.sv
src/in_order_completion_tracker.sv
tb/ioct_retire_checker.sv
tb/tb_top.sv
